// ===== rtl/core/brightness_to_dac_range_mapper_unit_assert.svh =====
// assertion macros for the brightness to dac range mapper
// used by bdm_ctrl; no other dependencies
`ifndef BRIGHTNESS_TO_DAC_RANGE_MAPPER_UNIT_ASSERT_SVH
`define BRIGHTNESS_TO_DAC_RANGE_MAPPER_UNIT_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BDM_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BDM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/bdm_pkg.sv =====
// shared types, constants and the range group table of the brightness mapper
// no dependencies
`default_nettype none

package bdm_pkg;

    localparam int GROUPS_MAX_DEF = 8;
    localparam int N_RES          = 8;
    localparam int N_EFF          = 6;
    localparam int GRP_IDX_W      = 3;
    localparam int LEVEL_W        = 32;
    localparam int CODE_W         = 8;
    localparam int NUM_W          = LEVEL_W + CODE_W;
    localparam int REM_W          = NUM_W + 2;
    localparam int DIV_STEPS      = CODE_W;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);
    localparam int DSH_W          = LEVEL_W + DIV_STEPS;

    localparam logic TC_RESOLUTION = 1'b0;
    localparam logic TC_EFFICIENCY = 1'b1;
    localparam logic TC_RESET      = TC_EFFICIENCY;

    typedef struct packed {
        logic               hdr;
        logic [1:0]         vref;
        logic [CODE_W-1:0]  dmin;
        logic [CODE_W-1:0]  steps;
        logic [LEVEL_W-1:0] lo;
        logic [LEVEL_W-1:0] hi;
    } t_group;

    typedef struct packed {
        logic load;
        logic search_step;
        logic clamp;
        logic mul;
        logic div_init;
        logic div_step;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic held;
        logic search_done;
    } t_status;

    function automatic t_group group_row(input logic tc, input logic [GRP_IDX_W-1:0] idx);
        t_group g;
        g = '0;
        if (tc == TC_EFFICIENCY) begin
            unique case (idx)
                3'd0:    g = '{1'b0, 2'd0, 8'd0,   8'd100, 32'd0,          32'd3705461};
                3'd1:    g = '{1'b0, 2'd1, 8'd50,  8'd0,   32'd3705461,    32'd3705461};
                3'd2:    g = '{1'b1, 2'd0, 8'd1,   8'd254, 32'd3705461,    32'd944892804};
                3'd3:    g = '{1'b1, 2'd1, 8'd128, 8'd127, 32'd948598266,  32'd1889785609};
                3'd4:    g = '{1'b1, 2'd2, 8'd187, 8'd68,  32'd1889785609, 32'd2576980377};
                3'd5:    g = '{1'b1, 2'd3, 8'd153, 8'd102, 32'd2576980377, 32'd4294967295};
                default: g = '0;
            endcase
        end else begin
            unique case (idx)
                3'd0:    g = '{1'b0, 2'd0, 8'd0,   8'd255, 32'd0,          32'd9448928};
                3'd1:    g = '{1'b0, 2'd1, 8'd128, 8'd127, 32'd9485982,    32'd18897856};
                3'd2:    g = '{1'b0, 2'd2, 8'd187, 8'd68,  32'd18897856,   32'd25769803};
                3'd3:    g = '{1'b0, 2'd3, 8'd153, 8'd102, 32'd25769803,   32'd42949672};
                3'd4:    g = '{1'b1, 2'd0, 8'd12,  8'd243, 32'd44465543,   32'd944892804};
                3'd5:    g = '{1'b1, 2'd1, 8'd128, 8'd127, 32'd948598266,  32'd1889785609};
                3'd6:    g = '{1'b1, 2'd2, 8'd187, 8'd68,  32'd1889785609, 32'd2576980377};
                default: g = '{1'b1, 2'd3, 8'd153, 8'd102, 32'd2576980377, 32'd4294967295};
            endcase
        end
        return g;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/bdm_channel_if.sv =====
// valid/ready channels for brightness requests and dac settings
// depends on bdm_pkg
`default_nettype none

interface bdm_in_if;
    import bdm_pkg::*;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] target_brightness;
    logic               undervoltage;

    modport source (output valid, output target_brightness, output undervoltage, input ready);
    modport sink   (input valid, input target_brightness, input undervoltage, output ready);
endinterface

interface bdm_out_if;
    import bdm_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         reference_select;
    logic [CODE_W-1:0]  dac_code;
    logic               high_range_on;
    logic               boost_on;
    logic [LEVEL_W-1:0] applied_level;
    logic               held;

    modport source (output valid, output reference_select, output dac_code,
                    output high_range_on, output boost_on, output applied_level,
                    output held, input ready);
    modport sink   (input valid, input reference_select, input dac_code,
                    input high_range_on, input boost_on, input applied_level,
                    input held, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bdm_ctrl.sv =====
// sequencer of the brightness mapper: handshakes, search, divide count, commit
// depends on bdm_pkg and the assertion macro header
`default_nettype none

`include "brightness_to_dac_range_mapper_unit_assert.svh"

module bdm_ctrl
    import bdm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire logic    i_out_ready,
    output logic         o_out_valid,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SEARCH = 8'b0000_0010,
        S_CLAMP  = 8'b0000_0100,
        S_MUL    = 8'b0000_1000,
        S_DIVI   = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_COMMIT = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state                r_state, n_state;
    logic [DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic                  r_out_valid, n_out_valid;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_status.held) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.search_step = 1'b1;
                    if (i_status.search_done) begin
                        n_state = S_CLAMP;
                    end
                end
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIVI;
            end
            S_DIVI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_OUT;
            end
            S_OUT: begin
                // wait for the output register to be free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `BDM_ASSERT_IMPLIES(a_no_overwrite, i_clk, i_rst_n, o_cmd.out_load, !r_out_valid || i_out_ready, "result overwritten before taken")
    `BDM_ASSERT_IMPLIES(a_div_complete, i_clk, i_rst_n, r_state == S_COMMIT, $past(r_state) == S_DIV && $past(r_cnt) == DIV_CNT_W'(DIV_STEPS - 1), "commit before all quotient bits")
    `BDM_ASSERT_NEXT(a_accept_starts, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SEARCH && !o_in_ready, "accepted item did not start")

endmodule

`default_nettype wire

// ===== rtl/core/bdm_datapath.sv =====
// datapath of the brightness mapper: search registers, clamp, multiply,
// restoring divider, setting state and output register; depends on bdm_pkg
`default_nettype none

module bdm_datapath
    import bdm_pkg::*;
#(
    parameter int GROUPS_MAX = GROUPS_MAX_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_wdata,
    input  wire logic [LEVEL_W-1:0] i_target_brightness,
    input  wire logic               i_undervoltage,
    input  wire t_cmd               i_cmd,
    output t_status                 o_status,
    output logic [1:0]              o_reference_select,
    output logic [CODE_W-1:0]       o_dac_code,
    output logic                    o_high_range_on,
    output logic                    o_boost_on,
    output logic [LEVEL_W-1:0]      o_applied_level,
    output logic                    o_held
);

    // search bounds hold -1 .. GROUPS_MAX-1
    localparam int SW    = $clog2(GROUPS_MAX) + 1;
    localparam int N_E   = (N_EFF < GROUPS_MAX) ? N_EFF : GROUPS_MAX;
    localparam int N_R   = (N_RES < GROUPS_MAX) ? N_RES : GROUPS_MAX;

    // configuration and setting state
    logic                 r_table_choice;
    logic [LEVEL_W-1:0]   r_last_level;
    logic                 r_boost;
    logic                 r_high_range;
    logic [1:0]           r_reference;
    logic [CODE_W-1:0]    r_dac;

    // working registers
    logic [LEVEL_W-1:0]   r_level;
    logic                 r_held;
    logic signed [SW-1:0] r_l, r_r;
    logic [GRP_IDX_W-1:0] r_idx;
    t_group               r_grp;
    logic [NUM_W-1:0]     r_num;
    logic [LEVEL_W-1:0]   r_den;
    logic                 r_live;
    logic [REM_W-1:0]     r_rem;
    logic [DSH_W-1:0]     r_dsh;
    logic [CODE_W-1:0]    r_q;

    // output register
    logic [1:0]           r_o_ref;
    logic [CODE_W-1:0]    r_o_dac;
    logic                 r_o_hr;
    logic                 r_o_boost;
    logic [LEVEL_W-1:0]   r_o_level;
    logic                 r_o_held;

    logic [LEVEL_W-1:0]   in_level;
    logic signed [SW-1:0] m, n_l, n_r;
    t_group               g_mid, g_sel;
    logic                 s_done;
    logic [GRP_IDX_W-1:0] s_idx;
    logic [LEVEL_W-1:0]   clamped;
    logic [REM_W-1:0]     trial;
    logic                 fits;

    assign in_level = i_undervoltage ? '0 : i_target_brightness;

    // one probe of the binary search per step
    always_comb begin
        m      = r_l + ((r_r - r_l) >>> 1);
        g_mid  = group_row(r_table_choice, GRP_IDX_W'(m));
        n_l    = r_l;
        n_r    = r_r;
        s_done = 1'b0;
        s_idx  = r_idx;
        if (r_l < r_r) begin
            if (r_level < g_mid.lo) begin
                n_r = m - SW'(1);
            end else if (r_level > g_mid.hi) begin
                n_l = m + SW'(1);
            end else begin
                s_done = 1'b1;
                s_idx  = GRP_IDX_W'(m);
            end
            if (!s_done && n_l == n_r) begin
                s_done = 1'b1;
                s_idx  = GRP_IDX_W'(n_l);
            end
        end else begin
            s_done = 1'b1;
            s_idx  = r_r[SW-1] ? '0 : GRP_IDX_W'(r_r);
        end
    end

    assign o_status.held        = r_held;
    assign o_status.search_done = s_done;

    assign g_sel = group_row(r_table_choice, r_idx);

    always_comb begin
        if (r_level < g_sel.lo) begin
            clamped = g_sel.lo;
        end else if (r_level > g_sel.hi) begin
            clamped = g_sel.hi;
        end else begin
            clamped = r_level;
        end
    end

    assign trial = r_rem - REM_W'(r_dsh);
    assign fits  = r_rem >= REM_W'(r_dsh);

    // control and setting state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_choice <= TC_RESET;
            r_last_level   <= '0;
            r_boost        <= 1'b0;
            r_high_range   <= 1'b0;
            r_reference    <= '0;
            r_dac          <= '0;
        end else begin
            if (i_cfg_we) begin
                r_table_choice <= i_cfg_wdata;
            end
            if (i_cmd.load && in_level != '0) begin
                r_boost <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_reference  <= r_grp.vref;
                r_dac        <= r_live ? r_grp.dmin + r_q : r_grp.dmin;
                r_high_range <= r_grp.hdr;
                r_last_level <= r_level;
                if (r_level == '0) begin
                    r_boost <= 1'b0;
                end
            end
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_level <= in_level;
            r_held  <= (in_level != '0) && (in_level == r_last_level);
            r_l     <= '0;
            r_r     <= (r_table_choice == TC_EFFICIENCY) ? SW'(N_E - 1) : SW'(N_R - 1);
        end
        if (i_cmd.search_step) begin
            r_l   <= n_l;
            r_r   <= n_r;
            r_idx <= s_idx;
        end
        if (i_cmd.clamp) begin
            r_grp   <= g_sel;
            r_level <= clamped;
        end
        if (i_cmd.mul) begin
            r_num  <= NUM_W'(r_grp.steps) * NUM_W'(r_level - r_grp.lo);
            r_den  <= r_grp.hi - r_grp.lo;
            r_live <= (r_grp.steps != '0) && (r_grp.hi > r_grp.lo);
        end
        // quotient of (2*num + den) / (2*den), always below 256
        if (i_cmd.div_init) begin
            r_rem <= REM_W'({r_num, 1'b0}) + REM_W'(r_den);
            r_dsh <= {r_den, 1'b0, {(DIV_STEPS - 1){1'b0}}};
            r_q   <= '0;
        end
        if (i_cmd.div_step) begin
            if (fits) begin
                r_rem <= trial;
            end
            r_q   <= {r_q[CODE_W-2:0], fits};
            r_dsh <= r_dsh >> 1;
        end
        if (i_cmd.out_load) begin
            r_o_ref   <= r_reference;
            r_o_dac   <= r_dac;
            r_o_hr    <= r_high_range;
            r_o_boost <= r_boost;
            r_o_level <= r_last_level;
            r_o_held  <= r_held;
        end
    end

    assign o_reference_select = r_o_ref;
    assign o_dac_code         = r_o_dac;
    assign o_high_range_on    = r_o_hr;
    assign o_boost_on         = r_o_boost;
    assign o_applied_level    = r_o_level;
    assign o_held             = r_o_held;

endmodule

`default_nettype wire

// ===== rtl/core/brightness_to_dac_range_mapper_unit.sv =====
// Maps a brightness request to a DAC setting (reference, 8-bit code, high-range
// flag, boost). One item at a time: a request equal to the last applied nonzero
// level (held) goes from the search state straight to the output state; any other
// request passes through up to four probes of the group search and the
// restoring divider that rounds the interpolated code. A new item is
// accepted while the previous result still waits in the output register; the
// result is held back only if that register is still full when it is ready.
// table_choice (reset 1, efficiency table) is written through i_cfg_we; the
// user must write it only while the block is idle; the block itself does not
// enforce this. Depends on bdm_pkg, bdm_channel_if, bdm_ctrl and bdm_datapath.
`default_nettype none

module brightness_to_dac_range_mapper_unit
    import bdm_pkg::*;
#(
    parameter int GROUPS_MAX = GROUPS_MAX_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_wdata,
    bdm_in_if.sink     i_in,
    bdm_out_if.source  o_out
);

    t_cmd    cmd;
    t_status status;

    bdm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    bdm_datapath #(
        .GROUPS_MAX (GROUPS_MAX)
    ) u_datapath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_target_brightness (i_in.target_brightness),
        .i_undervoltage      (i_in.undervoltage),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_reference_select  (o_out.reference_select),
        .o_dac_code          (o_out.dac_code),
        .o_high_range_on     (o_out.high_range_on),
        .o_boost_on          (o_out.boost_on),
        .o_applied_level     (o_out.applied_level),
        .o_held              (o_out.held)
    );

endmodule

`default_nettype wire
